FILE: rtl/stereo_feedback_echo_unit_macros.svh
// Assertion macros used by the checker file of the echo unit.
`ifndef STEREO_FEEDBACK_ECHO_UNIT_MACROS_SVH
`define STEREO_FEEDBACK_ECHO_UNIT_MACROS_SVH

// check a property on every clock edge outside reset
`define SFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every clock edge, reset included
`define SFE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sfe_pkg.sv
// Shared types, constants and helpers of the stereo feedback echo unit.
package sfe_pkg;

  localparam int DEPTH_DEFAULT = 131072;

  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 17;
  localparam int FB_W     = 15;
  localparam int MIX_W    = 16;
  localparam int GAIN_W   = 15;
  localparam int CFG_W    = 17;
  localparam int IDX_W    = 2;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(4800);
  localparam logic [FB_W-1:0]    FB_RESET    = FB_W'(13107);
  localparam logic [MIX_W-1:0]   MIX_RESET   = MIX_W'(16384);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16384);
  localparam logic [MIX_W-1:0]   MIX_UNITY   = MIX_W'(32768);

  typedef enum logic [IDX_W-1:0] {
    REG_DELAY = 2'd0,
    REG_FB    = 2'd1,
    REG_MIX   = 2'd2,
    REG_GAIN  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic load;
    logic hit;
    logic mul;
    logic mix;
  } ctrl_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [27:0] x);
    logic signed [SAMPLE_W-1:0] r;
    if (x > 28'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -28'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/stereo_feedback_echo_unit.sv
// Top level of the stereo feedback echo unit.
// Each stereo frame passes through these steps in order: accept and read of the delayed
// sample, feedback scaling, write-back and mix, output gain. The single
// read-modify-write of the two delay RAMs per frame keeps one frame in
// flight at a time; the last step waits while an earlier result sits untaken.
// The next frame is accepted while a finished result is still on the output.
// There is no clearing pass after reset: until the write position first wraps,
// entries not yet written read as zero, so the unit is ready at once.
module stereo_feedback_echo_unit import sfe_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [2*SAMPLE_W-1:0] s_tdata,   // sample_right, sample_left
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [2*SAMPLE_W-1:0] m_tdata,   // out_right, out_left
  input  logic                  cfg_write,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > DELAY_W) ? AW : DELAY_W;
  localparam logic [CW-1:0] MAX_DELAY = CW'(DEPTH - 1);
  localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW+1)'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_MIX, S_GAIN} state_t;

  state_t               state;
  logic [DELAY_W-1:0]   delay_len;
  logic [FB_W-1:0]      fb_gain;
  logic [MIX_W-1:0]     mix_amt;
  logic [GAIN_W-1:0]    out_gain;
  logic [AW-1:0]        wp;
  logic [AW-1:0]        wp_next;
  logic                 full;
  logic [CW-1:0]        delay_ext;
  logic [AW-1:0]        delay_c;
  logic [AW:0]          diff;
  logic [AW-1:0]        rd_addr;
  logic                 hit;
  logic [MIX_W-1:0]     mix_c;
  logic                 accept;
  logic                 out_free;
  ctrl_t                ctrl;
  logic signed [SAMPLE_W-1:0] res_left;
  logic signed [SAMPLE_W-1:0] res_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_len <= DELAY_RESET;
      fb_gain   <= FB_RESET;
      mix_amt   <= MIX_RESET;
      out_gain  <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DELAY: delay_len <= cfg_data[DELAY_W-1:0];
        REG_FB:    fb_gain   <= cfg_data[FB_W-1:0];
        REG_MIX:   mix_amt   <= cfg_data[MIX_W-1:0];
        REG_GAIN:  out_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign delay_ext = CW'(delay_len);

  always_comb begin
    if (delay_ext == '0) begin
      delay_c = AW'(1);
    end else if (delay_ext > MAX_DELAY) begin
      delay_c = LAST_POS;
    end else begin
      delay_c = delay_ext[AW-1:0];
    end
  end

  assign diff    = {1'b0, wp} - {1'b0, delay_c};
  assign rd_addr = diff[AW] ? AW'(diff + DEPTH_X) : diff[AW-1:0];
  assign hit     = full || (rd_addr < wp);
  assign wp_next = (wp == LAST_POS) ? '0 : wp + AW'(1);
  assign mix_c   = (mix_amt > MIX_UNITY) ? MIX_UNITY : mix_amt;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign ctrl.load = accept;
  assign ctrl.hit  = hit;
  assign ctrl.mul  = (state == S_MUL);
  assign ctrl.mix  = (state == S_MIX);

  sfe_channel #(.DEPTH(DEPTH)) u_left (
    .clk      (clk),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr),
    .wr_addr  (wp),
    .dry_in   ($signed(s_tdata[SAMPLE_W-1:0])),
    .fb_gain  (fb_gain),
    .mix_amt  (mix_c),
    .out_gain (out_gain),
    .result   (res_left)
  );

  sfe_channel #(.DEPTH(DEPTH)) u_right (
    .clk      (clk),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr),
    .wr_addr  (wp),
    .dry_in   ($signed(s_tdata[2*SAMPLE_W-1:SAMPLE_W])),
    .fb_gain  (fb_gain),
    .mix_amt  (mix_c),
    .out_gain (out_gain),
    .result   (res_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      wp       <= '0;
      full     <= 1'b0;
    end else begin
      if (state == S_GAIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_MIX;
        end
        S_MIX: begin
          wp <= wp_next;
          if (wp == LAST_POS) begin
            full <= 1'b1;
          end
          state <= S_GAIN;
        end
        S_GAIN: begin
          if (out_free) begin
            m_tdata <= {res_right, res_left};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sfe_channel.sv
// One channel of the echo: delay store, feedback write-back, output mix and output gain.
module sfe_channel import sfe_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  ctrl_t                      ctrl,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic signed [SAMPLE_W-1:0] dry_in,
  input  logic [FB_W-1:0]            fb_gain,
  input  logic [MIX_W-1:0]           mix_amt,
  input  logic [GAIN_W-1:0]          out_gain,
  output logic signed [SAMPLE_W-1:0] result
);

  logic signed [SAMPLE_W-1:0] dry;
  logic                       hit;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] scaled_next;
  logic signed [SAMPLE_W-1:0] stored;
  logic signed [40:0]         mixed;
  logic signed [40:0]         mixed_next;
  logic signed [FB_W:0]       fb_s;
  logic signed [MIX_W:0]      mix_s;
  logic signed [MIX_W:0]      dry_share;
  logic signed [39:0]         fb_prod;
  logic signed [39:0]         fb_round;
  logic signed [SAMPLE_W:0]   fb_sum;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [56:0]         g_prod;
  logic signed [56:0]         g_round;

  sfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ctrl.mix),
    .waddr (wr_addr),
    .wdata (stored),
    .re    (ctrl.load),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign delayed     = hit ? $signed(rdata) : '0;
  assign fb_s        = $signed({1'b0, fb_gain});
  assign fb_prod     = delayed * fb_s;
  assign fb_round    = fb_prod + 40'sd16384;
  assign scaled_next = fb_round[38:15];

  assign fb_sum = {dry[SAMPLE_W-1], dry} + {scaled[SAMPLE_W-1], scaled};
  assign stored = sat_sample(28'(fb_sum));

  assign mix_s      = $signed({1'b0, mix_amt});
  assign dry_share  = $signed({1'b0, MIX_UNITY}) - mix_s;
  assign mixed_next = dry * dry_share + scaled * mix_s;

  assign gain_s  = $signed({1'b0, out_gain});
  assign g_prod  = mixed * gain_s;
  assign g_round = g_prod + (57'sd1 <<< 28);
  assign result  = sat_sample(g_round[56:29]);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dry <= dry_in;
      hit <= ctrl.hit;
    end
    if (ctrl.mul) begin
      scaled <= scaled_next;
    end
    if (ctrl.mix) begin
      mixed <= mixed_next;
    end
  end

endmodule

FILE: rtl/sfe_checker.sv
// Port-level checks of the echo unit and their binding to the top level.
`include "stereo_feedback_echo_unit_macros.svh"

module sfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `SFE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
  `SFE_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "output word changed")
  `SFE_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second word taken early")
  `SFE_ASSERT(a_no_early_out, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result too early")
  `SFE_ASSERT_ALWAYS(a_reset_state, rst |=> !m_tvalid && s_tready, "reset state wrong")

endmodule

bind stereo_feedback_echo_unit sfe_checker u_sfe_checker (.*);
